// ===== sv/ded_pkg.sv =====
// ----------------------------------------------------------------------------
// ded_pkg
// Shared types and constants for the event deframer and coincidence core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ded_pkg;

    localparam int WORD_W      = 16;
    localparam int M_TDATA_W   = 136;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    // Number of events sharing one coarse tag that completes a coincidence.
    localparam logic [2:0] COINCIDENCE_TARGET = 3'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CHARGE_SUM_LOW   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARGE_SUM_HIGH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_CHANNEL     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_CHANNEL    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FINE_SELECT_CODE = 3'd4;

    // Configuration reset values.
    localparam logic [16:0] RST_CHARGE_SUM_LOW   = 17'd1800;
    localparam logic [16:0] RST_CHARGE_SUM_HIGH  = 17'd2800;
    localparam logic [7:0]  RST_LEFT_CHANNEL     = 8'd6;
    localparam logic [7:0]  RST_RIGHT_CHANNEL    = 8'd7;
    localparam logic [15:0] RST_FINE_SELECT_CODE = 16'd2;

    // Record kinds.
    localparam logic KIND_COINCIDENCE = 1'b0;
    localparam logic KIND_BAD_TYPE    = 1'b1;

    typedef struct packed {
        logic [16:0] charge_sum_low;
        logic [16:0] charge_sum_high;
        logic [7:0]  left_channel;
        logic [7:0]  right_channel;
        logic [15:0] fine_select_code;
    } cfg_t;

    // What the parser hands to the coincidence unit for the current word.
    typedef struct packed {
        logic        finish;      // a type 1 event completes on this word
        logic        bad_type;    // header closed with an unknown event type
        logic [31:0] event_type;
        logic [31:0] channel;
        logic [31:0] coarse_tag;
        logic [9:0]  fine_code;
        logic [15:0] charge;
    } parse_t;

    typedef struct packed {
        logic        record_kind;
        logic [32:0] coarse_time_ns;
        logic [16:0] fine_left_q6;
        logic [16:0] fine_right_q6;
        logic [15:0] charge_left;
        logic [15:0] charge_right;
        logic [31:0] bad_event_type;
    } result_t;

    // Fine code times 125, done as shifts and subtracts.
    function automatic logic [16:0] fine_to_q6(input logic [9:0] code);
        logic [16:0] x;
        x = {7'd0, code};
        return (x << 7) - (x << 1) - x;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ded_parser.sv =====
// ----------------------------------------------------------------------------
// ded_parser
// Word-by-word event stream parser: header, type 1 and type 2 bodies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ded_parser (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic [15:0]           word,
    input  wire logic [15:0]           fine_select_code,
    output ded_pkg::parse_t            parse
);

    localparam logic [4:0] P_SIZE_LO    = 5'd0;
    localparam logic [4:0] P_SIZE_HI    = 5'd1;
    localparam logic [4:0] P_TYPE_LO    = 5'd2;
    localparam logic [4:0] P_TYPE_HI    = 5'd3;
    localparam logic [4:0] P_CHAN_LO    = 5'd4;
    localparam logic [4:0] P_CHAN_HI    = 5'd5;
    localparam logic [4:0] P_TAG_LO     = 5'd6;
    localparam logic [4:0] P_TAG_HI     = 5'd7;
    localparam logic [4:0] P_SEL        = 5'd8;
    localparam logic [4:0] P_EX1        = 5'd9;
    localparam logic [4:0] P_EX2        = 5'd10;
    localparam logic [4:0] P_SGQ        = 5'd11;
    localparam logic [4:0] P_LGQ        = 5'd12;
    localparam logic [4:0] P_PU         = 5'd13;
    localparam logic [4:0] P_PROBE      = 5'd14;
    localparam logic [4:0] P_NS_LO      = 5'd15;
    localparam logic [4:0] P_NS_HI      = 5'd16;
    localparam logic [4:0] P_SAMPLES    = 5'd17;
    localparam logic [4:0] P_AN_LO      = 5'd18;
    localparam logic [4:0] P_AN_HI      = 5'd19;
    localparam logic [4:0] P_AN_SAMPLES = 5'd20;
    localparam logic [4:0] P_W_NS_LO    = 5'd21;
    localparam logic [4:0] P_W_NS_HI    = 5'd22;
    localparam logic [4:0] P_W_SAMPLES  = 5'd23;

    logic [4:0]  pos_reg, pos_next;
    logic [15:0] low_reg, low_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] chan_reg, chan_next;
    logic [31:0] tag_reg, tag_next;
    logic [15:0] sel_reg, sel_next;
    logic [9:0]  fine_reg, fine_next;
    logic [15:0] charge_reg, charge_next;
    logic [15:0] probe_reg, probe_next;
    logic [31:0] skip_reg, skip_next;

    logic [31:0] joined;
    logic [31:0] skip_dec;
    logic        finish;
    logic        bad_type;

    assign joined   = {word, low_reg};
    assign skip_dec = skip_reg - 32'd1;

    always_comb begin
        pos_next    = pos_reg;
        low_next    = low_reg;
        type_next   = type_reg;
        chan_next   = chan_reg;
        tag_next    = tag_reg;
        sel_next    = sel_reg;
        fine_next   = fine_reg;
        charge_next = charge_reg;
        probe_next  = probe_reg;
        skip_next   = skip_reg;
        finish      = 1'b0;
        bad_type    = 1'b0;
        case (pos_reg)
            P_SIZE_HI: pos_next = P_TYPE_LO;
            P_TYPE_LO: begin
                low_next = word;
                pos_next = P_TYPE_HI;
            end
            P_TYPE_HI: begin
                type_next = joined;
                pos_next  = P_CHAN_LO;
            end
            P_CHAN_LO: begin
                low_next = word;
                pos_next = P_CHAN_HI;
            end
            P_CHAN_HI: begin
                chan_next = joined;
                pos_next  = P_TAG_LO;
            end
            P_TAG_LO: begin
                low_next = word;
                pos_next = P_TAG_HI;
            end
            P_TAG_HI: begin
                tag_next = joined;
                if (type_reg == 32'd1) begin
                    pos_next = P_SEL;
                end else if (type_reg == 32'd2) begin
                    pos_next = P_W_NS_LO;
                end else begin
                    pos_next = P_SIZE_LO;
                    bad_type = 1'b1;
                end
            end
            P_SEL: begin
                sel_next = word;
                pos_next = P_EX1;
            end
            P_EX1: begin
                if (sel_reg == fine_select_code) begin
                    fine_next = word[9:0];
                end
                pos_next = P_EX2;
            end
            P_EX2: pos_next = P_SGQ;
            P_SGQ: pos_next = P_LGQ;
            P_LGQ: begin
                charge_next = word;
                pos_next    = P_PU;
            end
            P_PU: pos_next = P_PROBE;
            P_PROBE: begin
                probe_next = word;
                pos_next   = P_NS_LO;
            end
            P_NS_LO: begin
                low_next = word;
                pos_next = P_NS_HI;
            end
            P_NS_HI: begin
                skip_next = joined;
                if (joined != 32'd0) begin
                    pos_next = P_SAMPLES;
                end else if (probe_reg[15]) begin
                    pos_next = P_AN_LO;
                end else begin
                    pos_next = P_SIZE_LO;
                    finish   = 1'b1;
                end
            end
            P_SAMPLES: begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0) begin
                    if (probe_reg[15]) begin
                        pos_next = P_AN_LO;
                    end else begin
                        pos_next = P_SIZE_LO;
                        finish   = 1'b1;
                    end
                end
            end
            P_AN_LO: begin
                low_next = word;
                pos_next = P_AN_HI;
            end
            P_AN_HI: begin
                skip_next = joined;
                if ((probe_reg[1:0] inside {2'd1, 2'd2}) && joined != 32'd0) begin
                    pos_next = P_AN_SAMPLES;
                end else begin
                    pos_next = P_SIZE_LO;
                    finish   = 1'b1;
                end
            end
            P_AN_SAMPLES: begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0) begin
                    pos_next = P_SIZE_LO;
                    finish   = 1'b1;
                end
            end
            P_W_NS_LO: begin
                low_next = word;
                pos_next = P_W_NS_HI;
            end
            P_W_NS_HI: begin
                skip_next = joined;
                pos_next  = (joined != 32'd0) ? P_W_SAMPLES : P_SIZE_LO;
            end
            P_W_SAMPLES: begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0) begin
                    pos_next = P_SIZE_LO;
                end
            end
            default: begin
                // Size low word; any position outside the map lands here too.
                low_next = word;
                pos_next = P_SIZE_HI;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= P_SIZE_LO;
            low_reg    <= '0;
            type_reg   <= '0;
            chan_reg   <= '0;
            tag_reg    <= '0;
            sel_reg    <= '0;
            fine_reg   <= '0;
            charge_reg <= '0;
            probe_reg  <= '0;
            skip_reg   <= '0;
        end else if (step) begin
            pos_reg    <= pos_next;
            low_reg    <= low_next;
            type_reg   <= type_next;
            chan_reg   <= chan_next;
            tag_reg    <= tag_next;
            sel_reg    <= sel_next;
            fine_reg   <= fine_next;
            charge_reg <= charge_next;
            probe_reg  <= probe_next;
            skip_reg   <= skip_next;
        end
    end

    assign parse.finish     = finish;
    assign parse.bad_type   = bad_type;
    assign parse.event_type = type_reg;
    assign parse.channel    = chan_reg;
    assign parse.coarse_tag = tag_reg;
    assign parse.fine_code  = fine_reg;
    assign parse.charge     = charge_reg;

endmodule

`default_nettype wire

// ===== sv/ded_coinc.sv =====
// ----------------------------------------------------------------------------
// ded_coinc
// Left and right detector records, coincidence counting and charge window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ded_coinc (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire ded_pkg::cfg_t    cfg,
    input  wire ded_pkg::parse_t  parse,
    output logic                  res_valid,
    output ded_pkg::result_t      res
);

    logic [9:0]  left_fine_reg, left_fine_next;
    logic [15:0] left_charge_reg, left_charge_next;
    logic [9:0]  right_fine_reg, right_fine_next;
    logic [15:0] right_charge_reg, right_charge_next;
    logic [31:0] tag_reg, tag_next;
    logic [2:0]  count_reg, count_next;

    logic [2:0]  count_inc;
    logic [16:0] charge_sum;
    logic        in_window;
    logic        emit;

    assign count_inc  = count_reg + 3'd1;
    assign charge_sum = {1'b0, left_charge_next} + {1'b0, right_charge_next};
    assign in_window  = (charge_sum > cfg.charge_sum_low) &&
                        (charge_sum < cfg.charge_sum_high);

    always_comb begin
        left_fine_next    = left_fine_reg;
        left_charge_next  = left_charge_reg;
        right_fine_next   = right_fine_reg;
        right_charge_next = right_charge_reg;
        tag_next          = tag_reg;
        count_next        = count_reg;
        emit              = 1'b0;
        if (parse.finish) begin
            // The left record wins when both channel registers match.
            if (parse.channel == {24'd0, cfg.left_channel}) begin
                left_fine_next   = parse.fine_code;
                left_charge_next = parse.charge;
            end else if (parse.channel == {24'd0, cfg.right_channel}) begin
                right_fine_next   = parse.fine_code;
                right_charge_next = parse.charge;
            end
            if (parse.coarse_tag == tag_reg) begin
                if (count_inc == ded_pkg::COINCIDENCE_TARGET) begin
                    emit       = in_window;
                    count_next = 3'd1;
                end else begin
                    count_next = count_inc;
                end
            end else begin
                tag_next = parse.coarse_tag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_fine_reg    <= '0;
            left_charge_reg  <= '0;
            right_fine_reg   <= '0;
            right_charge_reg <= '0;
            tag_reg          <= '0;
            count_reg        <= 3'd1;
        end else if (step) begin
            left_fine_reg    <= left_fine_next;
            left_charge_reg  <= left_charge_next;
            right_fine_reg   <= right_fine_next;
            right_charge_reg <= right_charge_next;
            tag_reg          <= tag_next;
            count_reg        <= count_next;
        end
    end

    assign res_valid = emit || parse.bad_type;

    always_comb begin
        if (parse.bad_type) begin
            res                = '0;
            res.record_kind    = ded_pkg::KIND_BAD_TYPE;
            res.bad_event_type = parse.event_type;
        end else begin
            res.record_kind    = ded_pkg::KIND_COINCIDENCE;
            res.coarse_time_ns = {parse.coarse_tag, 1'b0};
            res.fine_left_q6   = ded_pkg::fine_to_q6(left_fine_next);
            res.fine_right_q6  = ded_pkg::fine_to_q6(right_fine_next);
            res.charge_left    = left_charge_next;
            res.charge_right   = right_charge_next;
            res.bad_event_type = '0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dpp_event_deframer_coincidence_core.sv =====
// Path: an accepted word waits in the input register; when it is consumed, its record (if any)
// is loaded into the output register, from which it can be taken.
// Throughput: one stream word per cycle; the parse step and coincidence update
// sit between the input register and the output register.
// The input waits only while a record is held unread and the buffered word makes another.
// Reset: synchronous, active low; clears parse state and records, sets the count to one, loads config defaults.
// ----------------------------------------------------------------------------
// dpp_event_deframer_coincidence_core
// Deframes a 16-bit digitizer event stream and emits two-channel coincidence
// records or unknown-type error records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpp_event_deframer_coincidence_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Stream input.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ded_pkg::WORD_W-1:0]        s_tdata,   // [15:0] data_word
    // Record output.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [32:0] coarse_time_ns, [49:33] fine_left_q6, [66:50] fine_right_q6,
    // [82:67] charge_left, [98:83] charge_right, [130:99] bad_event_type,
    // [135:131] zero
    output logic [ded_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                   m_tuser,   // [0] record_kind
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ded_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ded_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration registers. Writes are always taken at once.
    ded_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.charge_sum_low   <= ded_pkg::RST_CHARGE_SUM_LOW;
            cfg_reg.charge_sum_high  <= ded_pkg::RST_CHARGE_SUM_HIGH;
            cfg_reg.left_channel     <= ded_pkg::RST_LEFT_CHANNEL;
            cfg_reg.right_channel    <= ded_pkg::RST_RIGHT_CHANNEL;
            cfg_reg.fine_select_code <= ded_pkg::RST_FINE_SELECT_CODE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ded_pkg::REG_CHARGE_SUM_LOW:   cfg_reg.charge_sum_low  <= cfg_data;
                ded_pkg::REG_CHARGE_SUM_HIGH:  cfg_reg.charge_sum_high <= cfg_data;
                ded_pkg::REG_LEFT_CHANNEL:     cfg_reg.left_channel    <= cfg_data[7:0];
                ded_pkg::REG_RIGHT_CHANNEL:    cfg_reg.right_channel   <= cfg_data[7:0];
                ded_pkg::REG_FINE_SELECT_CODE: cfg_reg.fine_select_code <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Input register: holds one word until the parse stage consumes it.
    logic                       in_valid_reg;
    logic [ded_pkg::WORD_W-1:0] in_word_reg;
    logic                       consume;
    logic                       s_fire;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_word_reg <= s_tdata;
        end
    end

    // Parse and coincidence stage. Both only advance when the word is consumed.
    ded_pkg::parse_t  parse;
    ded_pkg::result_t res;
    logic             res_valid;

    ded_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (consume),
        .word             (in_word_reg),
        .fine_select_code (cfg_reg.fine_select_code),
        .parse            (parse)
    );

    ded_coinc u_coinc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (consume),
        .cfg       (cfg_reg),
        .parse     (parse),
        .res_valid (res_valid),
        .res       (res)
    );

    // A word that makes no record may always proceed; one that makes a record
    // waits until the output register is free or being drained.
    logic out_free;
    logic out_load;

    assign out_free = !m_tvalid || m_tready;
    assign consume  = in_valid_reg && (!res_valid || out_free);
    assign out_load = consume && res_valid;

    // Output register.
    logic             out_valid_reg;
    ded_pkg::result_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.record_kind;
    assign m_tdata  = {5'd0,
                       out_reg.bad_event_type,
                       out_reg.charge_right,
                       out_reg.charge_left,
                       out_reg.fine_right_q6,
                       out_reg.fine_left_q6,
                       out_reg.coarse_time_ns};

endmodule

`default_nettype wire

// ===== sv/ded_checker.sv =====
// ----------------------------------------------------------------------------
// ded_checker
// Port-level checks on the record output of the deframer core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ded_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [ded_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire logic                              m_tuser
);

    // A record that is not taken stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("record dropped while stalled");

    // Reset leaves no record on the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("record valid after reset");

    // An error record carries only the event type.
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[98:0] == 99'd0 && m_tdata[135:131] == 5'd0)
        else $error("error record carries coincidence fields");

    // A coincidence record has an even time and no error type.
    a_coinc_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[135:99] == 37'd0 && !m_tdata[0])
        else $error("coincidence record malformed");

    // Fine times never exceed 1023 * 125.
    a_fine_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[49:33] <= 17'd127875 &&
                                 m_tdata[66:50] <= 17'd127875)
        else $error("fine time out of range");

endmodule

bind dpp_event_deframer_coincidence_core ded_checker u_ded_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/tb_dpp_event_deframer_coincidence_core.sv =====
// ----------------------------------------------------------------------------
// tb_dpp_event_deframer_coincidence_core
// Self-checking bench for the event deframer and coincidence core. A short
// opening sequence is followed by randomly built event streams under several
// register settings. Every word that enters the core is run through an
// in-bench parser and coincidence model, and each record leaving the core is
// compared field by field with the oldest predicted record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dpp_event_deframer_coincidence_core;

    // Event type codes seen in the header type field.
    localparam logic [31:0] EVT_DPP      = 32'd1;
    localparam logic [31:0] EVT_WAVEFORM = 32'd2;
    // Analog probe types whose samples actually follow the analog count.
    localparam logic [1:0]  PROBE_TRACE_1 = 2'd1;
    localparam logic [1:0]  PROBE_TRACE_2 = 2'd2;

    localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 4;     // margin after the last predicted record
    localparam int PHASE_WORDS   = 200;
    localparam int LAST_PHASE    = 5;

    // Word position inside an event, as the parser walks it.
    typedef enum logic [4:0] {
        POS_SIZE_LO, POS_SIZE_HI, POS_TYPE_LO, POS_TYPE_HI,
        POS_CHAN_LO, POS_CHAN_HI, POS_TAG_LO, POS_TAG_HI,
        POS_SELECT, POS_EXTRAS1, POS_EXTRAS2, POS_SHORT_Q, POS_LONG_Q,
        POS_PILEUP, POS_PROBE, POS_NS_LO, POS_NS_HI, POS_SAMPLES,
        POS_AN_LO, POS_AN_HI, POS_AN_SAMPLES,
        POS_WAVE_NS_LO, POS_WAVE_NS_HI, POS_WAVE_SAMPLES
    } parse_pos_t;

    typedef struct packed {
        logic [15:0]      word;
        logic             typed;   // record below is the one this word must produce
        ded_pkg::result_t rec;
    } opening_row_t;

    localparam ded_pkg::result_t NO_REC = '0;
    // An unknown type of all ones must come back verbatim in an error record.
    localparam ded_pkg::result_t REC_BAD_ALL_ONES =
        {ded_pkg::KIND_BAD_TYPE, 33'd0, 17'd0, 17'd0, 16'd0, 16'd0, 32'hFFFF_FFFF};

    // Opening sequence: an all-ones header that must be rejected, then the
    // shortest possible DPP event carrying the largest fine code and charge.
    // Its tag matches the cleared coincidence tag, so the count reaches the
    // target at once, but the charge sum lies far above the default window.
    localparam opening_row_t OPENING [25] = '{
        {16'hFFFF, 1'b0, NO_REC},           // size
        {16'hFFFF, 1'b0, NO_REC},
        {16'hFFFF, 1'b0, NO_REC},           // type, all ones
        {16'hFFFF, 1'b0, NO_REC},
        {16'h0000, 1'b0, NO_REC},           // channel
        {16'h0000, 1'b0, NO_REC},
        {16'hFFFF, 1'b0, NO_REC},           // coarse tag
        {16'hFFFF, 1'b1, REC_BAD_ALL_ONES},
        {16'h0000, 1'b0, NO_REC},           // size
        {16'h0000, 1'b0, NO_REC},
        {16'h0001, 1'b0, NO_REC},           // type DPP
        {16'h0000, 1'b0, NO_REC},
        {16'h0006, 1'b0, NO_REC},           // default left channel
        {16'h0000, 1'b0, NO_REC},
        {16'h0000, 1'b0, NO_REC},           // coarse tag zero
        {16'h0000, 1'b0, NO_REC},
        {16'h0002, 1'b0, NO_REC},           // select equals default code
        {16'hFFFF, 1'b0, NO_REC},           // extras1, fine code 0x3FF
        {16'h0000, 1'b0, NO_REC},           // extras2
        {16'h0000, 1'b0, NO_REC},           // short charge
        {16'hFFFF, 1'b0, NO_REC},           // long charge
        {16'h0000, 1'b0, NO_REC},           // pile-up
        {16'h0000, 1'b0, NO_REC},           // probe, no analog trace
        {16'h0000, 1'b0, NO_REC},           // sample count zero
        {16'h0000, 1'b0, NO_REC}
    };

    // Register settings for the phases after the default one: wide open
    // window, a window no sum can enter, an inverted window with both
    // channels equal, a mid-range window, and back to the reset values.
    localparam ded_pkg::cfg_t PHASE_CFG [5] = '{
        {17'd0,      17'd131071, 8'd0,   8'd255, 16'h0000},
        {17'd131070, 17'd131071, 8'd255, 8'd0,   16'hFFFF},
        {17'd3000,   17'd1000,   8'd5,   8'd5,   16'hFFFF},
        {17'd1000,   17'd60000,  8'd200, 8'd17,  16'h1234},
        {ded_pkg::RST_CHARGE_SUM_LOW, ded_pkg::RST_CHARGE_SUM_HIGH,
         ded_pkg::RST_LEFT_CHANNEL, ded_pkg::RST_RIGHT_CHANNEL,
         ded_pkg::RST_FINE_SELECT_CODE}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [ded_pkg::M_TDATA_W-1:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [ded_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ded_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Model state: register copy, parser position and fields, channel
    // records and the coincidence counter.
    ded_pkg::cfg_t cfg_shadow = {ded_pkg::RST_CHARGE_SUM_LOW, ded_pkg::RST_CHARGE_SUM_HIGH,
                                 ded_pkg::RST_LEFT_CHANNEL, ded_pkg::RST_RIGHT_CHANNEL,
                                 ded_pkg::RST_FINE_SELECT_CODE};
    parse_pos_t  pos = POS_SIZE_LO;
    logic [15:0] low_word = '0;
    logic [31:0] ev_type = '0;
    logic [31:0] ev_channel = '0;
    logic [31:0] ev_tag = '0;
    logic [15:0] select_word = '0;
    logic [9:0]  fine_code = '0;
    logic [15:0] long_charge = '0;
    logic [15:0] probe_word = '0;
    logic [31:0] skip = '0;
    logic [9:0]  lt_fine = '0;
    logic [15:0] lt_charge = '0;
    logic [9:0]  rt_fine = '0;
    logic [15:0] rt_charge = '0;
    logic [31:0] coin_tag = '0;
    logic [2:0]  coin_count = 3'd1;

    ded_pkg::result_t expected_records [$];
    int          words_sent = 0;
    int          mismatches = 0;
    int          burst_left = 0;
    bit          sender_steady = 1'b0;
    int          rx_cycle = 0;
    int          rx_mode = 0;

    dpp_event_deframer_coincidence_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // A DPP event is complete: update the channel record it belongs to, then
    // run the coincidence count on its coarse tag. Returns 1 with a record
    // when the count reaches its target and the charge sum is inside the
    // window (both bounds exclusive).
    function automatic bit close_event(output ded_pkg::result_t rec);
        logic [16:0] charge_sum;
        close_event = 1'b0;
        rec = '0;
        pos = POS_SIZE_LO;
        if (ev_channel == {24'd0, cfg_shadow.left_channel}) begin
            lt_fine = fine_code;
            lt_charge = long_charge;
        end else if (ev_channel == {24'd0, cfg_shadow.right_channel}) begin
            rt_fine = fine_code;
            rt_charge = long_charge;
        end
        if (ev_tag == coin_tag) begin
            coin_count = coin_count + 3'd1;
            if (coin_count == ded_pkg::COINCIDENCE_TARGET) begin
                charge_sum = {1'b0, lt_charge} + {1'b0, rt_charge};
                if (charge_sum > cfg_shadow.charge_sum_low &&
                    charge_sum < cfg_shadow.charge_sum_high) begin
                    rec.record_kind    = ded_pkg::KIND_COINCIDENCE;
                    rec.coarse_time_ns = {ev_tag, 1'b0};
                    rec.fine_left_q6   = 17'(lt_fine) * 17'd125;
                    rec.fine_right_q6  = 17'(rt_fine) * 17'd125;
                    rec.charge_left    = lt_charge;
                    rec.charge_right   = rt_charge;
                    close_event = 1'b1;
                end
                coin_count = 3'd1;
            end
        end else begin
            coin_tag = ev_tag;
        end
    endfunction

    // The main sample block is done; an analog count may still follow.
    function automatic bit samples_done(output ded_pkg::result_t rec);
        rec = '0;
        if (probe_word[15]) begin
            pos = POS_AN_LO;
            return 1'b0;
        end
        return close_event(rec);
    endfunction

    // Advances the parser by one stream word; returns 1 when a record results.
    function automatic bit parse_word(input logic [15:0] w, output ded_pkg::result_t rec);
        parse_word = 1'b0;
        rec = '0;
        case (pos)
            POS_SIZE_HI: pos = POS_TYPE_LO;
            POS_TYPE_LO: begin
                low_word = w;
                pos = POS_TYPE_HI;
            end
            POS_TYPE_HI: begin
                ev_type = {w, low_word};
                pos = POS_CHAN_LO;
            end
            POS_CHAN_LO: begin
                low_word = w;
                pos = POS_CHAN_HI;
            end
            POS_CHAN_HI: begin
                ev_channel = {w, low_word};
                pos = POS_TAG_LO;
            end
            POS_TAG_LO: begin
                low_word = w;
                pos = POS_TAG_HI;
            end
            POS_TAG_HI: begin
                ev_tag = {w, low_word};
                if (ev_type == EVT_DPP) begin
                    pos = POS_SELECT;
                end else if (ev_type == EVT_WAVEFORM) begin
                    pos = POS_WAVE_NS_LO;
                end else begin
                    pos = POS_SIZE_LO;
                    rec.record_kind = ded_pkg::KIND_BAD_TYPE;
                    rec.bad_event_type = ev_type;
                    parse_word = 1'b1;
                end
            end
            POS_SELECT: begin
                select_word = w;
                pos = POS_EXTRAS1;
            end
            POS_EXTRAS1: begin
                // A fine code only counts when the select word says so.
                if (select_word == cfg_shadow.fine_select_code)
                    fine_code = w[9:0];
                pos = POS_EXTRAS2;
            end
            POS_EXTRAS2: pos = POS_SHORT_Q;
            POS_SHORT_Q: pos = POS_LONG_Q;
            POS_LONG_Q: begin
                long_charge = w;
                pos = POS_PILEUP;
            end
            POS_PILEUP: pos = POS_PROBE;
            POS_PROBE: begin
                probe_word = w;
                pos = POS_NS_LO;
            end
            POS_NS_LO: begin
                low_word = w;
                pos = POS_NS_HI;
            end
            POS_NS_HI: begin
                skip = {w, low_word};
                if (skip != 0)
                    pos = POS_SAMPLES;
                else
                    parse_word = samples_done(rec);
            end
            POS_SAMPLES: begin
                skip = skip - 32'd1;
                if (skip == 0)
                    parse_word = samples_done(rec);
            end
            POS_AN_LO: begin
                low_word = w;
                pos = POS_AN_HI;
            end
            POS_AN_HI: begin
                skip = {w, low_word};
                if ((probe_word[1:0] == PROBE_TRACE_1 || probe_word[1:0] == PROBE_TRACE_2) &&
                    skip != 0)
                    pos = POS_AN_SAMPLES;
                else
                    parse_word = close_event(rec);
            end
            POS_AN_SAMPLES: begin
                skip = skip - 32'd1;
                if (skip == 0)
                    parse_word = close_event(rec);
            end
            POS_WAVE_NS_LO: begin
                low_word = w;
                pos = POS_WAVE_NS_HI;
            end
            POS_WAVE_NS_HI: begin
                skip = {w, low_word};
                pos = (skip != 0) ? POS_WAVE_SAMPLES : POS_SIZE_LO;
            end
            POS_WAVE_SAMPLES: begin
                skip = skip - 32'd1;
                if (skip == 0)
                    pos = POS_SIZE_LO;
            end
            default: begin
                low_word = w;
                pos = POS_SIZE_HI;
            end
        endcase
    endfunction

    function automatic string show(input ded_pkg::result_t r);
        return $sformatf("kind %0d time %0h fine %0d/%0d charge %0d/%0d type %0h",
                         r.record_kind, r.coarse_time_ns, r.fine_left_q6, r.fine_right_q6,
                         r.charge_left, r.charge_right, r.bad_event_type);
    endfunction

    // Small sample counts keep events short; zero is common on purpose.
    function automatic logic [31:0] short_count();
        return ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(1, 4));
    endfunction

    // A channel field that mostly equals the given register, sometimes with
    // junk in the upper bits so the 32-bit compare must fail.
    function automatic logic [31:0] channel_word(input logic [7:0] ch);
        if ($urandom_range(0, 9) == 0)
            return {24'($urandom()), ch};
        return {24'd0, ch};
    endfunction

    // Word for noise and broken events: anything, except that sample counts
    // are forced small so a stray count cannot swallow the rest of the run.
    function automatic logic [15:0] noise_word();
        case (pos)
            POS_NS_LO, POS_AN_LO, POS_WAVE_NS_LO: return 16'($urandom_range(0, 5));
            POS_NS_HI, POS_AN_HI, POS_WAVE_NS_HI: return 16'd0;
            default: return 16'($urandom());
        endcase
    endfunction

    // Offers one word on the stream input, in bursts separated by random
    // gaps unless the phase runs steady. Called and returning at a falling
    // edge. The model sees the word at the edge where it is accepted.
    task automatic send_word(input logic [15:0] w, input logic typed = 1'b0,
                             input ded_pkg::result_t typed_rec = '0);
        ded_pkg::result_t rec;
        bit               got;
        if (burst_left == 0) begin
            if (!sender_steady) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata = w;
        do @(posedge aclk); while (!s_tready);
        got = parse_word(w, rec);
        if (typed)
            expected_records.push_back(typed_rec);
        else if (got)
            expected_records.push_back(rec);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send32(input logic [31:0] v);
        send_word(v[15:0]);
        send_word(v[31:16]);
    endtask

    task automatic send_header(input logic [31:0] kind, input logic [31:0] ch,
                               input logic [31:0] tag);
        send32($urandom());
        send32(kind);
        send32(ch);
        send32(tag);
    endtask

    // A well-formed DPP event with random content around the given fields.
    task automatic send_dpp(input logic [31:0] ch, input logic [31:0] tag,
                            input logic [15:0] charge);
        logic [15:0] probe;
        logic [31:0] n;
        bit          traced;
        probe = 16'($urandom());
        traced = (probe[1:0] == PROBE_TRACE_1 || probe[1:0] == PROBE_TRACE_2);
        send_header(EVT_DPP, ch, tag);
        send_word(($urandom_range(0, 4) != 0) ? cfg_shadow.fine_select_code
                                               : 16'($urandom()));
        send_word(16'($urandom()));   // extras1, fine code in the low bits
        send_word(16'($urandom()));   // extras2
        send_word(16'($urandom()));   // short charge
        send_word(charge);
        send_word(16'($urandom()));   // pile-up
        send_word(probe);
        n = short_count();
        send32(n);
        repeat (n) send_word(16'($urandom()));
        if (probe[15]) begin
            // Without a traced probe type the count is read but nothing
            // follows, so any 32-bit value is fair here.
            n = traced ? short_count() : $urandom();
            send32(n);
            if (traced)
                repeat (n) send_word(16'($urandom()));
        end
    endtask

    // Drops the input and waits until every predicted record has left the
    // core, then waits SETTLE_CYCLES more for anything still in the pipeline.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (expected_records.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [ded_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [ded_pkg::CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            ded_pkg::REG_CHARGE_SUM_LOW:   cfg_shadow.charge_sum_low = value;
            ded_pkg::REG_CHARGE_SUM_HIGH:  cfg_shadow.charge_sum_high = value;
            ded_pkg::REG_LEFT_CHANNEL:     cfg_shadow.left_channel = value[7:0];
            ded_pkg::REG_RIGHT_CHANNEL:    cfg_shadow.right_channel = value[7:0];
            ded_pkg::REG_FINE_SELECT_CODE: cfg_shadow.fine_select_code = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic program_registers(input ded_pkg::cfg_t c);
        write_register(ded_pkg::REG_CHARGE_SUM_LOW, c.charge_sum_low);
        write_register(ded_pkg::REG_CHARGE_SUM_HIGH, c.charge_sum_high);
        write_register(ded_pkg::REG_LEFT_CHANNEL, ded_pkg::CFG_DATA_W'(c.left_channel));
        write_register(ded_pkg::REG_RIGHT_CHANNEL, ded_pkg::CFG_DATA_W'(c.right_channel));
        write_register(ded_pkg::REG_FINE_SELECT_CODE,
                       ded_pkg::CFG_DATA_W'(c.fine_select_code));
        cfg_valid = 1'b0;
    endtask

    // Receiver back-pressure. A counter redraws the mode at random:
    // always ready, mostly ready, a fixed on/off pattern, or mostly stalled.
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 300 == 299)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 9) < 7);
            2:       m_tready <= (rx_cycle % 7) < 4;
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Every record leaving the core is matched against the oldest
    // prediction. Only the first ten failures are printed in full.
    always @(posedge aclk) begin : record_check
        ded_pkg::result_t got;
        ded_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.record_kind    = m_tuser;
            got.coarse_time_ns = m_tdata[32:0];
            got.fine_left_q6   = m_tdata[49:33];
            got.fine_right_q6  = m_tdata[66:50];
            got.charge_left    = m_tdata[82:67];
            got.charge_right   = m_tdata[98:83];
            got.bad_event_type = m_tdata[130:99];
            if (expected_records.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: record with none predicted: %s", $time, show(got));
            end else begin
                want = expected_records.pop_front();
                if (got.record_kind !== want.record_kind ||
                    got.coarse_time_ns !== want.coarse_time_ns ||
                    got.fine_left_q6 !== want.fine_left_q6 ||
                    got.fine_right_q6 !== want.fine_right_q6 ||
                    got.charge_left !== want.charge_left ||
                    got.charge_right !== want.charge_right ||
                    got.bad_event_type !== want.bad_event_type) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: record differs, expected %s", $time, show(want));
                        $display("%0t:                 actual   %s", $time, show(got));
                    end
                end
            end
        end
    end

    // Ends the run when no word moves on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready) || !aresetn)
                quiet = 0;
            else
                quiet++;
        end
        $display("dpp_event_deframer_coincidence_core: mismatch");
        $finish;
    end

    initial begin : stimulus
        int          first;
        int unsigned lo;
        int unsigned hi;
        int unsigned charge_sum;
        int unsigned cl;
        int unsigned cr;
        logic [31:0] tag;
        logic [31:0] ch;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < 25; i++)
            send_word(OPENING[i].word, OPENING[i].typed, OPENING[i].rec);

        for (int p = 0; p <= LAST_PHASE; p++) begin
            if (p > 0) begin
                wait_idle();
                program_registers(PHASE_CFG[p-1]);
            end
            sender_steady = ($urandom_range(0, 3) == 0);
            first = words_sent;
            while (words_sent - first < PHASE_WORDS) begin
                case ($urandom_range(0, 99)) inside
                    [0:54]: begin
                        // Left and right event on one tag, mostly a fresh one: the second
                        // one completes the coincidence. Most charge pairs
                        // are drawn so that their sum falls in the window.
                        tag = ($urandom_range(0, 9) == 0) ? coin_tag : $urandom();
                        lo = cfg_shadow.charge_sum_low;
                        hi = cfg_shadow.charge_sum_high;
                        if (lo + 1 < hi && $urandom_range(0, 9) < 7) begin
                            charge_sum = $urandom_range(hi - 1, lo + 1);
                            if (charge_sum > 131070)
                                charge_sum = 131070;
                            cl = $urandom_range((charge_sum < 65535) ? charge_sum : 65535,
                                                (charge_sum > 65535) ? charge_sum - 65535 : 0);
                            cr = charge_sum - cl;
                        end else begin
                            cl = $urandom_range(0, 65535);
                            cr = $urandom_range(0, 65535);
                        end
                        if ($urandom_range(0, 9) < 7) begin
                            send_dpp(channel_word(cfg_shadow.left_channel), tag, 16'(cl));
                            send_dpp(channel_word(cfg_shadow.right_channel), tag, 16'(cr));
                        end else begin
                            send_dpp(channel_word(cfg_shadow.right_channel), tag, 16'(cr));
                            send_dpp(channel_word(cfg_shadow.left_channel), tag, 16'(cl));
                        end
                        // A third event on the same tag completes a further coincidence.
                        if ($urandom_range(0, 6) == 0)
                            send_dpp(channel_word(cfg_shadow.left_channel), tag,
                                     16'($urandom()));
                    end
                    [55:69]: begin
                        case ($urandom_range(0, 2))
                            0:       ch = channel_word(cfg_shadow.left_channel);
                            1:       ch = channel_word(cfg_shadow.right_channel);
                            default: ch = $urandom();
                        endcase
                        send_dpp(ch, $urandom_range(0, 1) ? coin_tag : $urandom(),
                                 16'($urandom()));
                    end
                    [70:79]: begin
                        send_header(EVT_WAVEFORM, $urandom(), $urandom());
                        tag = short_count();
                        send32(tag);
                        repeat (tag) send_word(16'($urandom()));
                    end
                    [80:87]: begin
                        case ($urandom_range(0, 3))
                            0:       tag = 32'd0;
                            1:       tag = 32'd3;
                            2:       tag = 32'hFFFF_FFFE;
                            default: tag = $urandom();
                        endcase
                        if (tag == EVT_DPP || tag == EVT_WAVEFORM)
                            tag = 32'hFFFF_FFFF;
                        send_header(tag, $urandom(), $urandom());
                    end
                    [88:93]: begin
                        // Loose words from wherever the parser stands; the
                        // tail runs on until the next event boundary.
                        repeat ($urandom_range(1, 12)) send_word(noise_word());
                        while (pos != POS_SIZE_LO) send_word(noise_word());
                    end
                    default: begin
                        // A DPP event cut off after its header.
                        send_header(EVT_DPP, channel_word(cfg_shadow.left_channel),
                                    $urandom());
                        repeat ($urandom_range(0, 8)) send_word(noise_word());
                        while (pos != POS_SIZE_LO) send_word(noise_word());
                    end
                endcase
                // Now and then hold the input until the output has drained.
                if ($urandom_range(0, 24) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("dpp_event_deframer_coincidence_core: match");
        else
            $display("dpp_event_deframer_coincidence_core: mismatch");
        $finish;
    end

endmodule
